// ----- design/eq_pkg.sv -----
// Package: shared widths, constants, a division helper and the arctangent table function.
`timescale 1ns / 1ps
`default_nettype none
package eq_pkg;

  localparam int IN_W      = 31;
  localparam int OUT_W     = 32;
  localparam int CS_W      = 32;
  localparam int MAX_STEPS = 30;

  localparam logic signed [IN_W-1:0] PI_Q3_28        = 31'sd843314857;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [OUT_W:0]  ONE_Q30         = 33'sd1073741824;

  // Unsigned 64-bit quotient by shift and subtract.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int bi = 63; bi >= 0; bi--) begin
      rem = {rem[62:0], n[bi]};
      if (rem >= d) begin
        rem   = rem - d;
        q[bi] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) with 62 fraction bits, built by integer power series.
  // atan(1) is formed as atan(1/2) + atan(1/3).
  function automatic longint unsigned atan62(input int unsigned i);
    longint unsigned sum;
    longint unsigned p;
    longint unsigned t;
    longint unsigned d;
    int unsigned     k;
    sum = 64'd0;
    if (i == 0) begin
      // atan(1/2)
      p = 64'd1 << 61;
      for (k = 0; k < 40; k++) begin
        if (p != 64'd0) begin
          d = 64'(2 * k + 1);
          t = udiv64(p, d);
          if (k[0]) sum = sum - t;
          else      sum = sum + t;
          p = p >> 2;
        end
      end
      // atan(1/3)
      p = udiv64(64'd1 << 62, 64'd3);
      for (k = 0; k < 40; k++) begin
        if (p != 64'd0) begin
          d = 64'(2 * k + 1);
          t = udiv64(p, d);
          if (k[0]) sum = sum - t;
          else      sum = sum + t;
          p = udiv64(p, 64'd9);
        end
      end
    end else begin
      for (k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          d = 64'(2 * k + 1);
          t = udiv64(64'd1 << (62 - i * (2 * k + 1)), d);
          if (k[0]) sum = sum - t;
          else      sum = sum + t;
        end
      end
    end
    return sum;
  endfunction

endpackage
`default_nettype wire

// ----- design/eq_if.sv -----
// Interfaces: angle input channel and quaternion result channel.
`timescale 1ns / 1ps
`default_nettype none
interface eq_in_if;
  import eq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] roll_angle;
  logic signed [IN_W-1:0] pitch_angle;
  logic signed [IN_W-1:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface eq_out_if;
  import eq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] quat_w;
  logic signed [OUT_W-1:0] quat_x;
  logic signed [OUT_W-1:0] quat_y;
  logic signed [OUT_W-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

// ----- design/eq_cordic_lane.sv -----
// One pipelined CORDIC lane: half-angle cosine and sine, one step per stage.
`timescale 1ns / 1ps
`default_nettype none
module eq_cordic_lane #(
  parameter int STEPS      = 24,
  parameter int ANGLE_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic [STEPS:0]                 adv,
  input  wire logic signed [eq_pkg::IN_W-1:0] angle,
  output logic signed [eq_pkg::CS_W-1:0]      cos_out,
  output logic signed [eq_pkg::CS_W-1:0]      sin_out
);
  import eq_pkg::*;

  localparam int FRAC_Z = ANGLE_BITS - 4;

  logic signed [CS_W-1:0]       x_r [STEPS+1];
  logic signed [CS_W-1:0]       y_r [STEPS+1];
  logic signed [ANGLE_BITS-1:0] z_r [STEPS+1];

  logic signed [IN_W-1:0]       a_clamp;
  logic signed [63:0]           a_ext;
  logic signed [63:0]           z_scaled;

  // saturate to +-pi, then read as half angle in Q3.29 and align
  always_comb begin
    if (angle > PI_Q3_28)       a_clamp = PI_Q3_28;
    else if (angle < -PI_Q3_28) a_clamp = -PI_Q3_28;
    else                        a_clamp = angle;
    a_ext = 64'(a_clamp);
  end

  generate
    if (FRAC_Z >= 29) begin : g_shl
      assign z_scaled = a_ext <<< (FRAC_Z - 29);
    end else begin : g_shr
      assign z_scaled = a_ext >>> (29 - FRAC_Z);
    end
  endgenerate

  // entry stage
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_r[0] <= CORDIC_GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= z_scaled[ANGLE_BITS-1:0];
    end
  end

  // rotation stages
  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      localparam longint unsigned ATAN62 = atan62(k);
      localparam longint unsigned ATAN_RND =
        (ATAN62 + (64'd1 << (61 - FRAC_Z))) >> (62 - FRAC_Z);
      localparam logic signed [ANGLE_BITS-1:0] ATAN_Q = ATAN_RND[ANGLE_BITS-1:0];

      logic signed [CS_W-1:0] dx;
      logic signed [CS_W-1:0] dy;
      assign dx = y_r[k] >>> k;
      assign dy = x_r[k] >>> k;

      always_ff @(posedge clk) begin
        if (adv[k+1]) begin
          if (!z_r[k][ANGLE_BITS-1]) begin
            x_r[k+1] <= x_r[k] - dx;
            y_r[k+1] <= y_r[k] + dy;
            z_r[k+1] <= z_r[k] - ATAN_Q;
          end else begin
            x_r[k+1] <= x_r[k] + dx;
            y_r[k+1] <= y_r[k] - dy;
            z_r[k+1] <= z_r[k] + ATAN_Q;
          end
        end
      end
    end
  endgenerate

  assign cos_out = x_r[STEPS];
  assign sin_out = y_r[STEPS];

endmodule
`default_nettype wire

// ----- design/euler_to_quaternion_unit.sv -----
// Top level: Euler angles (roll, pitch, yaw) to Z-Y-X unit quaternion.
//
// Fully pipelined: one angle triple may be accepted every clock cycle while the
// pipeline is not stalled, and each result passes through STEPS+4 register stages:
// one clamp/align stage, one stage per CORDIC step in each of three parallel
// lanes, a stage for the four pair products, a stage for the eight triple
// products, and an output register that adds and saturates. Each stage holds
// its transaction while the stage after it is full and stalled, so bubbles are
// squeezed out and nothing is dropped or repeated. Outputs are Q1.30 clipped
// to +-1.0. CORDIC_STEPS outside 1..30 is clamped to that range.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_unit #(
  parameter int CORDIC_STEPS = 24,
  parameter int ANGLE_BITS   = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  eq_in_if.sink     in_ch,
  eq_out_if.source  out_ch
);
  import eq_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS :
                         ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam int N = STEPS + 4;
  localparam int S_M1  = STEPS + 1;
  localparam int S_M2  = STEPS + 2;
  localparam int S_OUT = STEPS + 3;

  logic [N-1:0] v_r;
  logic [N:0]   ok;

  logic signed [CS_W-1:0] cr, sr, cp, sp, cy, sy;

  // stage k may load when it is empty or its transaction moves on
  assign ok[N] = out_ch.ready;
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_ok
      assign ok[g] = !v_r[g] || ok[g+1];
    end
  endgenerate

  assign in_ch.ready = ok[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ok[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < N; k++) begin
        if (ok[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  eq_cordic_lane #(.STEPS(STEPS), .ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .adv(ok[STEPS:0]), .angle(in_ch.roll_angle), .cos_out(cr), .sin_out(sr)
  );
  eq_cordic_lane #(.STEPS(STEPS), .ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .adv(ok[STEPS:0]), .angle(in_ch.pitch_angle), .cos_out(cp), .sin_out(sp)
  );
  eq_cordic_lane #(.STEPS(STEPS), .ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .adv(ok[STEPS:0]), .angle(in_ch.yaw_angle), .cos_out(cy), .sin_out(sy)
  );

  // pair products roll x pitch, back to Q1.30
  logic signed [63:0]     m_cc, m_ss, m_sc, m_cs;
  logic signed [CS_W-1:0] cc_r, ss_r, sc_r, cs_r;
  logic signed [CS_W-1:0] cy_r, sy_r;

  assign m_cc = 64'(cr) * 64'(cp);
  assign m_ss = 64'(sr) * 64'(sp);
  assign m_sc = 64'(sr) * 64'(cp);
  assign m_cs = 64'(cr) * 64'(sp);

  always_ff @(posedge clk) begin
    if (ok[S_M1]) begin
      cc_r <= m_cc[61:30];
      ss_r <= m_ss[61:30];
      sc_r <= m_sc[61:30];
      cs_r <= m_cs[61:30];
      cy_r <= cy;
      sy_r <= sy;
    end
  end

  // triple products with yaw
  logic signed [63:0]     t_ccc, t_sss, t_scc, t_css, t_csc, t_scs, t_ccs, t_ssc;
  logic signed [CS_W-1:0] ccc_r, sss_r, scc_r, css_r, csc_r, scs_r, ccs_r, ssc_r;

  assign t_ccc = 64'(cc_r) * 64'(cy_r);
  assign t_sss = 64'(ss_r) * 64'(sy_r);
  assign t_scc = 64'(sc_r) * 64'(cy_r);
  assign t_css = 64'(cs_r) * 64'(sy_r);
  assign t_csc = 64'(cs_r) * 64'(cy_r);
  assign t_scs = 64'(sc_r) * 64'(sy_r);
  assign t_ccs = 64'(cc_r) * 64'(sy_r);
  assign t_ssc = 64'(ss_r) * 64'(cy_r);

  always_ff @(posedge clk) begin
    if (ok[S_M2]) begin
      ccc_r <= t_ccc[61:30];
      sss_r <= t_sss[61:30];
      scc_r <= t_scc[61:30];
      css_r <= t_css[61:30];
      csc_r <= t_csc[61:30];
      scs_r <= t_scs[61:30];
      ccs_r <= t_ccs[61:30];
      ssc_r <= t_ssc[61:30];
    end
  end

  function automatic logic signed [OUT_W-1:0] sat_q30(input logic signed [OUT_W:0] v);
    logic signed [OUT_W:0] r;
    if (v > ONE_Q30)       r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    else                   r = v;
    return r[OUT_W-1:0];
  endfunction

  // combine and saturate into the output register
  logic signed [OUT_W:0] sum_w, sum_x, sum_y, sum_z;
  logic signed [OUT_W-1:0] qw_r, qx_r, qy_r, qz_r;

  assign sum_w = 33'(ccc_r) + 33'(sss_r);
  assign sum_x = 33'(scc_r) - 33'(css_r);
  assign sum_y = 33'(csc_r) + 33'(scs_r);
  assign sum_z = 33'(ccs_r) - 33'(ssc_r);

  always_ff @(posedge clk) begin
    if (ok[S_OUT]) begin
      qw_r <= sat_q30(sum_w);
      qx_r <= sat_q30(sum_x);
      qy_r <= sat_q30(sum_y);
      qz_r <= sat_q30(sum_z);
    end
  end

  assign out_ch.valid  = v_r[S_OUT];
  assign out_ch.quat_w = qw_r;
  assign out_ch.quat_x = qx_r;
  assign out_ch.quat_y = qy_r;
  assign out_ch.quat_z = qz_r;

  // an accepted transaction lands in the entry stage
  a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted transaction missing from entry stage");

  // a blocked entry stage keeps its transaction
  a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !ok[0] |=> v_r[0])
    else $error("stalled entry stage lost its transaction");

  // w and z results never exceed +-1.0
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (33'(out_ch.quat_w) <= ONE_Q30) && (33'(out_ch.quat_w) >= -ONE_Q30)
                  && (33'(out_ch.quat_z) <= ONE_Q30) && (33'(out_ch.quat_z) >= -ONE_Q30))
    else $error("quaternion component out of range");

endmodule
`default_nettype wire

// ----- bench/tb_euler_to_quaternion_unit.sv -----
// Testbench: Euler-to-quaternion unit checked against a bit-exact CORDIC predictor.
`timescale 1ns / 1ps
module tb_euler_to_quaternion_unit;
  import eq_pkg::*;

  localparam int STEPS     = 24;
  localparam int FRAC_Z    = 28;   // ANGLE_BITS - 4
  localparam int N_RANDOM  = 400;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LONG = 200;

  typedef struct packed {
    logic signed [IN_W-1:0] roll;
    logic signed [IN_W-1:0] pitch;
    logic signed [IN_W-1:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] w;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } quat_t;

  logic clk;
  logic rst_n;
  eq_in_if  in_ch();
  eq_out_if out_ch();

  euler_to_quaternion_unit #(.CORDIC_STEPS(STEPS), .ANGLE_BITS(32)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  angles_t angle_q[$];
  quat_t   quat_expected_q[$];
  longint  atan_tab[STEPS];
  int      mismatches = 0;
  bit      stim_done = 0;
  bit      hold_seen = 0;
  int      idle_cycles = 0;

  // Arithmetic shift right rounding toward minus infinity.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Half-angle sine and cosine in Q1.30 by rotation-mode CORDIC.
  function automatic void half_sin_cos(logic signed [IN_W-1:0] raw,
                                       output longint c, output longint s);
    longint a, z, xv, yv, dx, dy;
    a = raw;
    if (a > 843314857) a = 843314857;
    if (a < -843314857) a = -843314857;
    z = floor_shr(a, 29 - FRAC_Z);
    xv = 652032874;
    yv = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shr(yv, i);
      dy = floor_shr(xv, i);
      if (z >= 0) begin
        xv -= dx; yv += dy; z -= atan_tab[i];
      end else begin
        xv += dx; yv -= dy; z += atan_tab[i];
      end
    end
    c = xv;
    s = yv;
  endfunction

  function automatic longint triple(longint a, longint b, longint c);
    return floor_shr(floor_shr(a * b, 30) * c, 30);
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_unit(longint v);
    if (v > 1073741824) v = 1073741824;
    if (v < -1073741824) v = -1073741824;
    return v[OUT_W-1:0];
  endfunction

  function automatic quat_t zyx_quaternion(angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_sin_cos(a.roll, cr, sr);
    half_sin_cos(a.pitch, cp, sp);
    half_sin_cos(a.yaw, cy, sy);
    q.w = clip_unit(triple(cr, cp, cy) + triple(sr, sp, sy));
    q.x = clip_unit(triple(sr, cp, cy) - triple(cr, sp, sy));
    q.y = clip_unit(triple(cr, sp, cy) + triple(sr, cp, sy));
    q.z = clip_unit(triple(cr, cp, sy) - triple(sr, sp, cy));
    return q;
  endfunction

  function automatic longint unsigned atan_recip_62(longint unsigned n);
    longint unsigned p, sum;
    int k;
    p = (64'd1 << 62) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      if (k % 2) sum -= p / (2 * k + 1);
      else sum += p / (2 * k + 1);
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned atan_half_third();
    return atan_recip_62(2) + atan_recip_62(3);
  endfunction

  function automatic longint unsigned atan_pow2_62(int i);
    longint unsigned sum;
    sum = 0;
    for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
      if (k % 2) sum -= (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
      else sum += (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
    end
    return sum;
  endfunction

  // Arctangent table in the angle accumulator format, rounded half up.
  function automatic void build_atan_table();
    longint unsigned t62;
    for (int i = 0; i < STEPS; i++) begin
      if (i == 0) t62 = atan_half_third();
      else t62 = atan_pow2_62(i);
      atan_tab[i] = longint'((t62 + (64'd1 << (61 - FRAC_Z))) >> (62 - FRAC_Z));
    end
  endfunction

  // Random angle: mostly in range, sometimes raw 31-bit or edge values.
  function automatic logic signed [IN_W-1:0] rand_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return IN_W'($signed($urandom_range(0, 1686629714)) - 843314857);
    if (sel == 7) return IN_W'($urandom);
    if (sel == 8) return $urandom_range(0, 1) ? PI_Q3_28 : -PI_Q3_28;
    return IN_W'($signed($urandom_range(0, 3)) - 2);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Stimulus: directed corners, then random triples.
  initial begin
    logic signed [IN_W-1:0] corners[10];
    angles_t a;
    build_atan_table();
    corners = '{31'sd0, 31'sd843314857, -31'sd843314857, 31'sd843314858,
                -31'sd843314858, 31'sh3FFFFFFF, 31'sh40000000, 31'sd1, -31'sd1,
                31'sd421657428};
    for (int i = 0; i < 10; i++) begin
      a.roll = corners[i]; a.pitch = 0; a.yaw = 0; angle_q.push_back(a);
      a.roll = 0; a.pitch = corners[i]; a.yaw = corners[9 - i]; angle_q.push_back(a);
    end
    a.roll = PI_Q3_28; a.pitch = PI_Q3_28; a.yaw = PI_Q3_28; angle_q.push_back(a);
    a.roll = -PI_Q3_28; a.pitch = -PI_Q3_28; a.yaw = -PI_Q3_28; angle_q.push_back(a);
    for (int i = 0; i < N_RANDOM; i++) begin
      a.roll = rand_angle(); a.pitch = rand_angle(); a.yaw = rand_angle();
      angle_q.push_back(a);
    end
    stim_done = 1;
  end

  // Driver: offers queued triples with random gaps.
  int in_gap = 0;
  angles_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.roll_angle <= '0;
      in_ch.pitch_angle <= '0;
      in_ch.yaw_angle <= '0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur = {in_ch.roll_angle, in_ch.pitch_angle, in_ch.yaw_angle};
        quat_expected_q.push_back(zyx_quaternion(cur));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (angle_q.size() > 0) begin
          cur = angle_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.roll_angle <= cur.roll;
          in_ch.pitch_angle <= cur.pitch;
          in_ch.yaw_angle <= cur.yaw;
          in_gap <= gap_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure; one long hold-off once the pipe is busy.
  int out_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_seen && quat_expected_q.size() > 5) begin
      hold_seen <= 1;
      hold_cnt <= HOLD_LONG;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  quat_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z};
      if (quat_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                                       got.w, got.x, got.y, got.z);
      end else begin
        want = quat_expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL euler_to_quaternion_unit");
      $finish;
    end
  end

  // Reset, then wait for drain and report.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.roll_angle = '0;
    in_ch.pitch_angle = '0;
    in_ch.yaw_angle = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    @(posedge clk);
    while (angle_q.size() > 0 || in_ch.valid || quat_expected_q.size() > 0)
      @(posedge clk);
    repeat (STEPS + 40) @(posedge clk);
    if (mismatches == 0 && quat_expected_q.size() == 0) begin
      $display("PASS euler_to_quaternion_unit");
    end else begin
      $display("FAIL euler_to_quaternion_unit");
    end
    $finish;
  end

endmodule
